// ===== rtl/blkmma_pkg.sv =====
// Package for the block matrix multiply-accumulate element.
// Holds payload structs, field widths, register codes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package blkmma_pkg;

  localparam int DATA_W      = 32;
  localparam int BLOCK_DIM_W = 4;
  localparam int ROUNDS_W    = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int DEF_MAX_DIM = 8;
  localparam int MAX_ROUNDS  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_DIM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS    = 1'b1;

  localparam logic [BLOCK_DIM_W-1:0] BLOCK_DIM_RST = 4'd8;
  localparam logic [ROUNDS_W-1:0]    ROUNDS_RST    = 5'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] a_element;
    logic signed [DATA_W-1:0] b_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_element;
    logic                     last_of_run;
  } out_item_t;

endpackage

// ===== rtl/block_matrix_multiply_accumulate_top.sv =====
// Top level of the block matrix multiply-accumulate element (one Cannon PE).
// Holds the A, B and C block memories, the product sequencer and output stage.
// Depends on blkmma_pkg.
`timescale 1ns / 1ps

// Each input transfer carries one A and one B element, row-major, for a block
// of side d (block_dim, clamped to 1..MAX_DIM). Loading accepts an element
// on each transfer. After the d*d-th element the input stalls for the
// product pass, one product term per cycle through the single 32x32
// multiplier, and for the pipeline drain after it. The A and B memories
// each have one read port, which limits the pass to one term per cycle. After
// 'rounds' block pairs (clamped to 1..16) the accumulator is sent out
// row-major, one element per cycle while the output is not stalled, with
// last_of_run on the final element; input transfers resume as soon as the
// final element sits in the output register. There is no clearing pass: one
// written flag per accumulator entry is cleared at reset and when a run
// completes, and an entry whose flag is low reads as zero, so each run starts
// from an all-zero accumulator whatever the block size does between rounds.
// Sums wrap modulo 2^32. Configuration is taken at any cycle with cfg_we high
// and acts at once; write it only while idle.
module block_matrix_multiply_accumulate_top #(
  parameter int MAX_DIM = blkmma_pkg::DEF_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  blkmma_pkg::in_item_t             in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output blkmma_pkg::out_item_t            out_data,
  input  logic                             cfg_we,
  input  logic [blkmma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blkmma_pkg::CFG_DATA_W-1:0] cfg_data
);

  import blkmma_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // block stores
  logic [DATA_W-1:0] a_mem [CELLS];
  logic [DATA_W-1:0] b_mem [CELLS];
  logic [DATA_W-1:0] c_mem [CELLS];
  logic [DATA_W-1:0] a_q, b_q, c_q;
  logic [CELLS-1:0]  c_vld_r;

  // config
  logic [BLOCK_DIM_W-1:0] block_dim_r;
  logic [ROUNDS_W-1:0]    rounds_r;
  logic [DW-1:0]          dim_eff;
  logic [IW-1:0]          dim_last;
  logic [CNT_W-1:0]       n_cells;
  logic [ROUNDS_W-1:0]    rounds_eff;

  // control
  logic [1:0]          state_r;
  logic [IDX_W-1:0]    pos_r;
  logic [ROUNDS_W-1:0] round_r;

  // product sequencer, stage 0 (address issue)
  logic [IW-1:0]    i_r, j_r, k_r;
  logic             issue_r;
  logic [IDX_W-1:0] a_addr, b_addr, c_addr;
  logic             k_first, k_last;

  // stage 1 (memory data) and stage 2 (product, accumulate)
  logic             s1_vld_r, s1_first_r, s1_last_r;
  logic [IDX_W-1:0] s1_addr_r;
  logic             s2_vld_r, s2_first_r, s2_last_r;
  logic [IDX_W-1:0] s2_addr_r;
  logic [DATA_W-1:0] prod_r, cbase_r, acc_r, acc_nxt;
  logic             mac_done;
  logic             run_end;

  // emit
  logic [CNT_W-1:0] emit_cnt_r;
  logic             pend_r, pend_last_r;
  logic             out_vld_r;
  out_item_t        out_data_r;
  logic             out_free, out_load, emit_rd;

  logic             c_re;
  logic [IDX_W-1:0] c_raddr;
  logic             in_acc;
  logic [CNT_W-1:0] pos_inc;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_dim_r <= BLOCK_DIM_RST;
      rounds_r    <= ROUNDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_DIM: block_dim_r <= cfg_data[BLOCK_DIM_W-1:0];
        REG_ROUNDS:    rounds_r    <= cfg_data[ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    if (block_dim_r == '0) begin
      dim_eff = DW'(1);
    end else if (block_dim_r > BLOCK_DIM_W'(MAX_DIM)) begin
      dim_eff = DW'(MAX_DIM);
    end else begin
      dim_eff = DW'(block_dim_r);
    end
    if (rounds_r == '0) begin
      rounds_eff = ROUNDS_W'(1);
    end else if (rounds_r > ROUNDS_W'(MAX_ROUNDS)) begin
      rounds_eff = ROUNDS_W'(MAX_ROUNDS);
    end else begin
      rounds_eff = rounds_r;
    end
  end

  assign dim_last = IW'(dim_eff - DW'(1));
  assign n_cells  = CNT_W'(dim_eff) * CNT_W'(dim_eff);

  // ---------------------------------------------------------------- load
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign pos_inc  = CNT_W'(pos_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_mem[pos_r] <= in_data.a_element;
      b_mem[pos_r] <= in_data.b_element;
    end
  end

  // ---------------------------------------------------------------- product
  // element (i,j) lives at i*d+j
  assign a_addr  = IDX_W'(CNT_W'(i_r) * CNT_W'(dim_eff) + CNT_W'(k_r));
  assign b_addr  = IDX_W'(CNT_W'(k_r) * CNT_W'(dim_eff) + CNT_W'(j_r));
  assign c_addr  = IDX_W'(CNT_W'(i_r) * CNT_W'(dim_eff) + CNT_W'(j_r));
  assign k_first = (k_r == '0);
  assign k_last  = (k_r == dim_last);

  always_ff @(posedge clk) begin
    a_q <= a_mem[a_addr];
    b_q <= b_mem[b_addr];
  end

  // C read: first term of each (i,j) during the pass, sequential while emitting
  always_comb begin
    if (state_r == ST_EMIT) begin
      c_re    = emit_rd;
      c_raddr = emit_cnt_r[IDX_W-1:0];
    end else begin
      c_re    = issue_r && k_first;
      c_raddr = c_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (c_re) begin
      c_q <= c_mem[c_raddr];
    end
  end

  // each (i,j) owns its own C entry, so the stream needs no interlock
  assign acc_nxt = (s2_first_r ? cbase_r : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_last_r) begin
      c_mem[s2_addr_r] <= acc_nxt;
    end
  end

  // written flags; cleared when the final pass of a run is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
    end else if (run_end) begin
      c_vld_r <= '0;
    end else if (s2_vld_r && s2_last_r) begin
      c_vld_r[s2_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= k_first;
    s1_last_r  <= k_last;
    s1_addr_r  <= c_addr;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_addr_r  <= s1_addr_r;
    prod_r     <= DATA_W'(a_q * b_q);
    if (s1_first_r) begin
      cbase_r <= c_vld_r[s1_addr_r] ? c_q : '0;
    end
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign mac_done = (state_r == ST_MAC) && !issue_r && !s1_vld_r && !s2_vld_r;
  assign run_end  = mac_done && (round_r + ROUNDS_W'(1) >= rounds_eff);

  // ---------------------------------------------------------------- emit
  assign out_free = !out_vld_r || !out_stall;
  assign out_load = pend_r && out_free;
  assign emit_rd  = (state_r == ST_EMIT) && (emit_cnt_r < n_cells) &&
                    (!pend_r || out_load);

  always_ff @(posedge clk) begin
    if (emit_rd) begin
      pend_last_r <= (emit_cnt_r == n_cells - CNT_W'(1));
    end
    if (out_load) begin
      out_data_r.c_element   <= c_q;
      out_data_r.last_of_run <= pend_last_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      pos_r      <= '0;
      round_r    <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      issue_r    <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      emit_cnt_r <= '0;
      pend_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= issue_r;
      s2_vld_r <= s1_vld_r;

      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (pos_inc >= n_cells) begin
              pos_r   <= '0;
              i_r     <= '0;
              j_r     <= '0;
              k_r     <= '0;
              issue_r <= 1'b1;
              state_r <= ST_MAC;
            end else begin
              pos_r <= pos_inc[IDX_W-1:0];
            end
          end
        end

        ST_MAC: begin
          if (issue_r) begin
            if (!k_last) begin
              k_r <= k_r + IW'(1);
            end else begin
              k_r <= '0;
              if (j_r != dim_last) begin
                j_r <= j_r + IW'(1);
              end else begin
                j_r <= '0;
                if (i_r != dim_last) begin
                  i_r <= i_r + IW'(1);
                end else begin
                  issue_r <= 1'b0;
                end
              end
            end
          end
          if (mac_done) begin
            if (round_r + ROUNDS_W'(1) >= rounds_eff) begin
              round_r    <= '0;
              emit_cnt_r <= '0;
              pend_r     <= 1'b0;
              state_r    <= ST_EMIT;
            end else begin
              round_r <= round_r + ROUNDS_W'(1);
              state_r <= ST_LOAD;
            end
          end
        end

        ST_EMIT: begin
          if (emit_rd) begin
            pend_r     <= 1'b1;
            emit_cnt_r <= emit_cnt_r + CNT_W'(1);
          end else if (out_load) begin
            pend_r <= 1'b0;
          end
          // leave once the final element moves into the output register
          if (emit_cnt_r == n_cells && out_load) begin
            state_r <= ST_LOAD;
          end
        end

        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== sim/blkmma_checker.sv =====
// Scoreboard for the block matrix multiply-accumulate element.
// Tracks config writes, predicts the C block for each completed run and checks results.
// Depends on blkmma_pkg.
`timescale 1ns / 1ps

module blkmma_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  blkmma_pkg::in_item_t              in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  blkmma_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  logic [blkmma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blkmma_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                mismatches,
  output int                                outstanding
);
  import blkmma_pkg::*;

  localparam int CELLS = DEF_MAX_DIM * DEF_MAX_DIM;

  logic [DATA_W-1:0]      a_store [CELLS];
  logic [DATA_W-1:0]      b_store [CELLS];
  logic [DATA_W-1:0]      c_acc   [CELLS];
  logic [6:0]             load_pos;
  logic [4:0]             round_idx;
  logic [BLOCK_DIM_W-1:0] dim_reg;
  logic [ROUNDS_W-1:0]    rounds_reg;
  out_item_t              c_expected [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin : predict
    int unsigned       dim;
    int unsigned       rnd;
    int unsigned       cells;
    int unsigned       pos;
    int                errs;
    logic [DATA_W-1:0] dot;
    out_item_t         want;
    errs = 0;
    if (!rst_n) begin
      foreach (c_acc[i]) begin
        a_store[i] = '0;
        b_store[i] = '0;
        c_acc[i]   = '0;
      end
      load_pos   = '0;
      round_idx  = '0;
      dim_reg    = BLOCK_DIM_RST;
      rounds_reg = ROUNDS_RST;
      c_expected.delete();
      mismatches <= 0;
    end else begin
      // results leaving this edge come from earlier inputs
      if (out_valid && !out_stall) begin
        if (c_expected.size() == 0) begin
          $error("c_element: no result expected, actual %0d", $signed(out_data.c_element));
          errs++;
        end else begin
          want = c_expected.pop_front();
          if (out_data.c_element !== want.c_element) begin
            $error("c_element: expected %0d, actual %0d",
                   $signed(want.c_element), $signed(out_data.c_element));
            errs++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b",
                   want.last_of_run, out_data.last_of_run);
            errs++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_DIM: dim_reg    = cfg_data[BLOCK_DIM_W-1:0];
          REG_ROUNDS:    rounds_reg = cfg_data[ROUNDS_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        dim = (dim_reg == 0) ? 1 : ((dim_reg > DEF_MAX_DIM) ? DEF_MAX_DIM : dim_reg);
        rnd = (rounds_reg == 0) ? 1 : ((rounds_reg > MAX_ROUNDS) ? MAX_ROUNDS : rounds_reg);
        cells = dim * dim;
        pos = load_pos % CELLS;
        a_store[pos] = in_data.a_element;
        b_store[pos] = in_data.b_element;
        load_pos = 7'(pos + 1);
        // load_pos may already be past the count if block_dim shrank mid-block
        if (load_pos >= cells) begin
          load_pos = '0;
          for (int i = 0; i < dim; i++) begin
            for (int j = 0; j < dim; j++) begin
              dot = '0;
              for (int k = 0; k < dim; k++)
                dot += a_store[i*dim+k] * b_store[k*dim+j];
              c_acc[i*dim+j] = c_acc[i*dim+j] + dot;
            end
          end
          round_idx = round_idx + 1'b1;
          if (round_idx >= rnd) begin
            round_idx = '0;
            for (int t = 0; t < cells; t++) begin
              want.c_element   = c_acc[t];
              want.last_of_run = (t == cells - 1);
              c_expected.push_back(want);
            end
            foreach (c_acc[i]) c_acc[i] = '0;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
    outstanding <= c_expected.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the block matrix multiply-accumulate element.
// Drives clock, reset, config and both channels; verdict from blkmma_checker.
// Depends on blkmma_pkg, blkmma_checker and block_matrix_multiply_accumulate_top.
`timescale 1ns / 1ps

module tb;
  import blkmma_pkg::*;

  // Covers the longest product pass plus the pipeline drain; rounded up.
  localparam int SETTLE    = DEF_MAX_DIM * DEF_MAX_DIM * DEF_MAX_DIM + 8;
  localparam int HOLD_OFF  = 400;
  localparam int PHASES    = 9;
  localparam logic [DATA_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ALL_ONE = 32'hffff_ffff;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int outstanding;

  // Idle rates in percent; the sender switches them as transfers go by.
  int send_pct = 7;
  int recv_pct = 51;
  int sent     = 0;
  bit hold_req = 1'b0;

  // Random phases: block_dim write, rounds write, item count (whole runs).
  // 15, 31 and 0 exercise the clamps; rounds 16 only at small sizes.
  int ph_dim    [PHASES] = '{1, 2, 3, 4, 15, 5, 6, 7, 2};
  int ph_rounds [PHASES] = '{31, 16, 2, 1, 1, 3, 0, 1, 5};
  int ph_items  [PHASES] = '{32, 64, 36, 48, 64, 75, 36, 49, 40};

  always #6 clk = ~clk;

  block_matrix_multiply_accumulate_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blkmma_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Mostly full-range random words, with the corner values mixed in often
  // enough that overflowing products and sums show up regularly.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(11))
      0:       return POS_MAX;
      1:       return NEG_MAX;
      2:       return ALL_ONE;
      3:       return '0;
      4:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // One input transfer. Random idle cycles go in front, valid then stays up
  // until the block takes the item. Called and returning on a rising edge.
  task automatic send_item(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    in_item_t item;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.a_element = a;
    item.b_element = b;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    // idle schedule: receiver-heavy, then sender-heavy, then none
    if (sent == 150) begin
      send_pct = 51;
      recv_pct = 7;
    end else if (sent == 300) begin
      send_pct = 0;
      recv_pct = 0;
    end
  endtask

  // Register write; the spare cycle keeps back-to-back writes from putting
  // two assignments on cfg_we in one step.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Quiesce: stop offering, wait for every predicted result, then give a
  // product pass that produced nothing time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Result side: random stall, plus one long hold-off when asked for. The
  // hold-off counts its own cycles so the sender keeps pushing and the block
  // backs up into its input.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // block_dim 0 is taken as 1: every transfer is a full 1x1 run.
    // Corner operands: overflow wrap, min*min, min*max, -1*0.
    set_reg(REG_BLOCK_DIM, 5'd0);
    set_reg(REG_ROUNDS, 5'd1);
    send_item(POS_MAX, POS_MAX);
    send_item(NEG_MAX, NEG_MAX);
    send_item(NEG_MAX, POS_MAX);
    send_item(ALL_ONE, '0);
    settle();

    // rounds lowered mid-run: two rounds in with rounds=3, then rounds=1;
    // the next completion already meets the count and emits the sum of three.
    set_reg(REG_ROUNDS, 5'd3);
    send_item(POS_MAX, 32'd2);
    send_item(ALL_ONE, ALL_ONE);
    settle();
    set_reg(REG_ROUNDS, 5'd1);
    send_item(NEG_MAX, ALL_ONE);
    settle();

    // rounds 0 is taken as 1; one 2x2 block with corner values
    set_reg(REG_BLOCK_DIM, 5'd2);
    set_reg(REG_ROUNDS, 5'd0);
    send_item(POS_MAX, NEG_MAX);
    send_item(ALL_ONE, 32'd1);
    send_item(NEG_MAX, POS_MAX);
    send_item(32'd1, ALL_ONE);
    settle();

    // block_dim shrunk mid-block: three of four 2x2 elements loaded, then
    // block_dim=1; the next transfer completes a 1x1 block from entry 0.
    set_reg(REG_ROUNDS, 5'd1);
    send_item(32'd7, ALL_ONE);
    send_item(32'd3, 32'd5);
    send_item(NEG_MAX, 32'd9);
    settle();
    set_reg(REG_BLOCK_DIM, 5'd1);
    send_item(ALL_ONE, POS_MAX);
    settle();

    // --- random phases, whole runs each ---
    for (int p = 0; p < PHASES; p++) begin
      set_reg(REG_BLOCK_DIM, CFG_DATA_W'(ph_dim[p]));
      set_reg(REG_ROUNDS, CFG_DATA_W'(ph_rounds[p]));
      // 4x4 runs back to back: stall the results so the block fills up
      if (p == 3)
        hold_req = 1'b1;
      repeat (ph_items[p]) send_item(pick_word(), pick_word());
      settle();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
